>>> rtl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Types and codes shared by the double-ended queue modules.
// ----------------------------------------------------------------------------
package dqe_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] value;
    } deq_in_t;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic        [4:0]  count;
        logic               is_empty;
        status_t            status;
    } deq_out_t;

    // Whole-chain move requested by the control logic.
    typedef struct packed {
        logic shift_up;        // insert at cell 0, everything moves one up
        logic shift_down;      // drop cell 0, everything moves one down
        logic write_at_count;  // store at the first free cell
    } chain_ctrl_t;

    // What one cell does this cycle.
    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } cell_ctrl_t;

endpackage

>>> rtl/dqe_cell.sv
// ----------------------------------------------------------------------------
// dqe_cell
// One storage cell of the queue chain: holds one word, takes it from a
// neighbor on a shift or from the insert bus on a load.
// ----------------------------------------------------------------------------
module dqe_cell #(
    parameter int WORD_BITS = 32
) (
    input  logic                   clk,
    input  dqe_pkg::cell_ctrl_t    ctrl,
    input  logic [WORD_BITS-1:0]   up_word,    // from the lower neighbor
    input  logic [WORD_BITS-1:0]   down_word,  // from the upper neighbor
    input  logic [WORD_BITS-1:0]   ins_word,
    output logic [WORD_BITS-1:0]   word
);
    import dqe_pkg::*;

    logic [WORD_BITS-1:0] data_reg;
    logic [WORD_BITS-1:0] data_next;

    always_comb
    begin
        if (ctrl.shift_up)
        begin
            data_next = up_word;
        end
        else if (ctrl.shift_down)
        begin
            data_next = down_word;
        end
        else if (ctrl.load)
        begin
            data_next = ins_word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;

endmodule

>>> rtl/dqe_chain.sv
// ----------------------------------------------------------------------------
// dqe_chain
// Row of DEPTH cells with the end word fixed at cell 0. Shifts move the
// whole row one place; a load lands at the cell whose index equals count.
// ----------------------------------------------------------------------------
module dqe_chain #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32,
    parameter int CW        = 5
) (
    input  logic                   clk,
    input  dqe_pkg::chain_ctrl_t   ctrl,
    input  logic [CW-1:0]          count,
    input  logic [WORD_BITS-1:0]   ins_word,
    output logic [WORD_BITS-1:0]   end_word
);
    import dqe_pkg::*;

    logic [WORD_BITS-1:0] words [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t           cc;
        logic [WORD_BITS-1:0] up_w;
        logic [WORD_BITS-1:0] down_w;

        assign cc.shift_up   = ctrl.shift_up;
        assign cc.shift_down = ctrl.shift_down;
        assign cc.load       = ctrl.write_at_count && (count == CW'(i));

        if (i == 0)
        begin : g_first
            assign up_w = ins_word;
        end
        else
        begin : g_mid
            assign up_w = words[i-1];
        end

        // top cell has no upper neighbor; its word falls out of range
        if (i == DEPTH - 1)
        begin : g_last
            assign down_w = words[i];
        end
        else
        begin : g_inner
            assign down_w = words[i+1];
        end

        dqe_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cc),
            .up_word   (up_w),
            .down_word (down_w),
            .ins_word  (ins_word),
            .word      (words[i])
        );
    end

    assign end_word = words[0];

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words built from two rows of cells.
// ----------------------------------------------------------------------------
// Takes one command per item (push front, push back, pop front, pop back,
// clear, query; codes 6 and 7 behave as query) and returns one result item
// describing the queue afterwards: front and back words (-1 when empty),
// count, empty flag and status (done, push dropped because full, pop on
// empty ignored). The result of a command is shown in the cycle after it is
// taken; a new command is accepted whenever no result is waiting or
// the waiting one is taken in the same cycle, so the block sustains one item
// per clock with no stall on the result side. Storage is two chains of DEPTH
// cells: the front chain keeps the front word in cell 0, the back chain keeps
// the back word in cell 0. A push at one end shifts that end's chain up and
// writes the other chain at the first free cell; a pop shifts its own chain
// down and only lowers the count for the other. Both result words therefore
// come straight from cell 0 registers, with no wide read mux. Slot contents
// are not reset; clear only zeroes the count. Stored words hold the pushed
// value cut or sign-extended to WORD_BITS, and go out likewise at 32 bits.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dqe_pkg::deq_in_t   cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dqe_pkg::deq_out_t  rsp_item
);
    import dqe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    status_t              status_reg;
    status_t              status_next;
    logic                 rsp_vld_reg;
    logic                 rsp_vld_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    chain_ctrl_t          front_ctrl;
    chain_ctrl_t          back_ctrl;
    logic [WORD_BITS-1:0] ins_word;
    logic [WORD_BITS-1:0] front_word;
    logic [WORD_BITS-1:0] back_word;
    logic [31:0]          front_ext;
    logic [31:0]          back_ext;
    logic [CW+4:0]        count_wide;

    // State only moves when the result slot is free or being emptied.
    assign cmd_stall = rsp_vld_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Narrow or widen the pushed word to the stored width.
    if (WORD_BITS <= 32)
    begin : g_ins_narrow
        assign ins_word = cmd_item.value[WORD_BITS-1:0];
    end
    else
    begin : g_ins_wide
        assign ins_word = {{(WORD_BITS-32){cmd_item.value[31]}}, cmd_item.value};
    end

    // Back to 32 bits: sign-extended from WORD_BITS, or truncated when wider.
    if (WORD_BITS >= 32)
    begin : g_out_wide
        assign front_ext = front_word[31:0];
        assign back_ext  = back_word[31:0];
    end
    else
    begin : g_out_narrow
        assign front_ext = {{(32-WORD_BITS){front_word[WORD_BITS-1]}}, front_word};
        assign back_ext  = {{(32-WORD_BITS){back_word[WORD_BITS-1]}}, back_word};
    end

    // Command decode: chain moves, next count and status.
    always_comb
    begin
        front_ctrl  = '0;
        back_ctrl   = '0;
        count_next  = count_reg;
        status_next = ST_DONE;
        case (cmd_item.cmd)
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_ctrl.shift_up      = 1'b1;
                    back_ctrl.write_at_count = 1'b1;
                    count_next               = count_reg + 1'b1;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    back_ctrl.shift_up        = 1'b1;
                    front_ctrl.write_at_count = 1'b1;
                    count_next                = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    front_ctrl.shift_down = 1'b1;
                    count_next            = count_reg - 1'b1;
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    back_ctrl.shift_down = 1'b1;
                    count_next           = count_reg - 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                // query and unused codes leave the queue alone
            end
        endcase
        if (!accept)
        begin
            front_ctrl  = '0;
            back_ctrl   = '0;
            count_next  = count_reg;
            status_next = status_reg;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_vld_next = rsp_vld_reg;
        end
        else
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            status_reg  <= ST_DONE;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            status_reg  <= status_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    dqe_chain #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_front (
        .clk      (clk),
        .ctrl     (front_ctrl),
        .count    (count_reg),
        .ins_word (ins_word),
        .end_word (front_word)
    );

    dqe_chain #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .CW        (CW)
    ) u_back (
        .clk      (clk),
        .ctrl     (back_ctrl),
        .count    (count_reg),
        .ins_word (ins_word),
        .end_word (back_word)
    );

    // Result comes straight from the state; it cannot move while it waits.
    assign count_wide = {5'b0, count_reg};

    assign rsp_valid            = rsp_vld_reg;
    assign rsp_item.front_value = empty ? '1 : front_ext;
    assign rsp_item.back_value  = empty ? '1 : back_ext;
    assign rsp_item.count       = count_wide[4:0];
    assign rsp_item.is_empty    = empty;
    assign rsp_item.status      = status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
        else $error("accepted item produced no result");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status_reg == ST_FULL |-> count_reg == CW'(DEPTH))
        else $error("full status with room left");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status_reg == ST_EMPTY |-> empty)
        else $error("pop-on-empty status with words stored");

    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && count_reg == CW'(1) |-> front_word == back_word)
        else $error("front and back chains disagree on single word");

endmodule
